@@ src/pmst_pkg.sv @@
package pmst_pkg;

  // Default sizes handed to the top level
  localparam int unsigned VERTICES_DEF    = 16;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // Fixed widths of the item fields on the ports
  localparam int unsigned VTX_FIELD_W    = 4;
  localparam int unsigned WEIGHT_FIELD_W = 16;
  localparam int unsigned CMD_W          = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_e;

  // Controls from the sequencer to the edge store
  typedef struct packed {
    logic clear;    // start a sweep that removes every edge
    logic write;    // write one matrix entry
    logic present;  // present bit for that write
    logic read;     // fetch one matrix entry
  } edge_ctrl_t;

endpackage

@@ src/prim_minimum_spanning_tree_top.sv @@
// Minimum spanning tree engine (dense Prim) over a stored VERTICES x VERTICES
// weight matrix.
// Input channel (in_valid_i/in_ready_o): one item per command. A clear item
// removes every edge by sweeping the matrix; the same sweep runs after reset,
// and no item is taken until it is done. A run item grows a tree from
// start_vertex_i over vertices 0..top_vertex_i.
// Output channel (out_valid_o/out_ready_i): a run gives one item per tree
// vertex in selection order and then an end marker with last_o set.
// A run first sets up the keys, then for each selected vertex does one scan,
// one emit step and one relaxation pass, and ends with a final scan and the
// marker. The scan walks the vertex table, the relaxation the vertex table
// and the matrix row, one entry a cycle through one shared comparator.
// A run is one item at a time: the input is not ready until the end marker is
// in the output register. A stalled receiver holds the sequencer at its next
// result; the next command is still accepted while the marker waits.
module prim_minimum_spanning_tree_top #(
  parameter int unsigned VERTICES    = pmst_pkg::VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pmst_pkg::CMD_W-1:0]          command_i,
  input  logic [pmst_pkg::VTX_FIELD_W-1:0]    edge_source_i,
  input  logic [pmst_pkg::VTX_FIELD_W-1:0]    edge_target_i,
  input  logic [pmst_pkg::WEIGHT_FIELD_W-1:0] edge_weight_i,
  input  logic                                edge_exists_i,
  input  logic [pmst_pkg::VTX_FIELD_W-1:0]    start_vertex_i,
  input  logic [pmst_pkg::VTX_FIELD_W-1:0]    top_vertex_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pmst_pkg::VTX_FIELD_W-1:0]    vertex_o,
  output logic [pmst_pkg::VTX_FIELD_W-1:0]    parent_o,
  output logic [pmst_pkg::WEIGHT_FIELD_W-1:0] key_o,
  output logic                                found_o,
  output logic                                last_o
);

  localparam int unsigned VW  = $clog2(VERTICES);
  localparam int unsigned KW  = WEIGHT_BITS + 1;
  localparam int unsigned VTW = 1 + VW + KW;
  localparam int unsigned FW  = pmst_pkg::VTX_FIELD_W;
  localparam int unsigned KFW = pmst_pkg::WEIGHT_FIELD_W;
  localparam logic [KW-1:0] INF_KEY  = {1'b1, {WEIGHT_BITS{1'b0}}};
  localparam logic [VW-1:0] LAST_VTX = VW'(VERTICES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_EMIT,
    S_RELAX,
    S_END
  } state_e;

  state_e          state_q, state_d;
  logic [VW-1:0]   cnt_q, cnt_d;
  logic            iss_done_q, iss_done_d;
  logic            pv_q, pv_d;
  logic [VW-1:0]   pi_q, pi_d;
  logic [VW-1:0]   top_q, top_d;
  logic [VW-1:0]   start_q, start_d;
  logic            start_ok_q, start_ok_d;
  logic [VW-1:0]   cur_q, cur_d;
  logic [KW-1:0]   best_key_q, best_key_d;
  logic [VW-1:0]   best_par_q, best_par_d;
  logic            have_q, have_d;
  logic            out_valid_q, out_valid_d;
  logic [FW-1:0]   out_vertex_q, out_vertex_d;
  logic [FW-1:0]   out_parent_q, out_parent_d;
  logic [KFW-1:0]  out_key_q, out_key_d;
  logic            out_found_q, out_found_d;
  logic            out_last_q, out_last_d;

  // Vertex table: {in-tree mark, parent, key}
  logic [VTW-1:0]  vtx_mem [VERTICES];
  logic [VTW-1:0]  vr_q;
  logic            vw_en;
  logic [VW-1:0]   vw_addr;
  logic [VTW-1:0]  vw_data;

  logic                 rd_mark;
  logic [VW-1:0]        rd_par;
  logic [KW-1:0]        rd_key;

  pmst_pkg::edge_ctrl_t edge_ctrl;
  logic                 edge_busy;
  logic                 edge_present;
  logic [WEIGHT_BITS-1:0] edge_weight;

  logic            in_fire, out_free, src_ok, dst_ok, is_root;
  logic [VW-1:0]   top_cl;
  logic [KW-1:0]   cmp_a, cmp_b;
  logic            cmp_gt, take, relax_upd;

  assign in_ready_o = (state_q == S_IDLE) && !edge_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign src_ok     = int'(edge_source_i) < VERTICES;
  assign dst_ok     = int'(edge_target_i) < VERTICES;
  assign top_cl     = (int'(top_vertex_i) > VERTICES - 1) ? LAST_VTX : VW'(top_vertex_i);

  assign rd_mark = vr_q[VTW-1];
  assign rd_par  = vr_q[KW +: VW];
  assign rd_key  = vr_q[KW-1:0];

  assign edge_ctrl.clear   = in_fire && (command_i == pmst_pkg::CMD_CLEAR);
  assign edge_ctrl.write   = in_fire && (command_i == pmst_pkg::CMD_WRITE) && src_ok && dst_ok;
  assign edge_ctrl.present = edge_exists_i;
  assign edge_ctrl.read    = (state_q == S_RELAX) && !iss_done_q;

  pmst_edge_store #(
    .VERTICES    (VERTICES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_edge_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (edge_ctrl),
    .wr_row_i     (VW'(edge_source_i)),
    .wr_col_i     (VW'(edge_target_i)),
    .wr_weight_i  (WEIGHT_BITS'(edge_weight_i)),
    .rd_row_i     (cur_q),
    .rd_col_i     (cnt_q),
    .busy_o       (edge_busy),
    .rd_present_o (edge_present),
    .rd_weight_o  (edge_weight)
  );

  // Shared comparator: key scan picks a strictly smaller key, relaxation
  // checks whether the edge undercuts the stored key.
  assign cmp_a = (state_q == S_RELAX) ? rd_key : best_key_q;
  assign cmp_b = (state_q == S_RELAX) ? {1'b0, edge_weight} : rd_key;

  pmst_cmp #(
    .WIDTH (KW)
  ) u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .gt_o (cmp_gt)
  );

  assign take      = pv_q && !rd_mark && (!have_q || cmp_gt);
  assign relax_upd = pv_q && edge_present && !rd_mark && cmp_gt;
  assign is_root   = start_ok_q && (cnt_q == start_q);

  always_comb begin
    vw_en   = 1'b0;
    vw_addr = cnt_q;
    vw_data = {1'b0, {VW{1'b0}}, INF_KEY};
    case (state_q)
      S_INIT: begin
        vw_en   = 1'b1;
        vw_data = is_root ? {1'b0, start_q, {KW{1'b0}}} : {1'b0, {VW{1'b0}}, INF_KEY};
      end
      S_EMIT: begin
        vw_en   = out_free;
        vw_addr = cur_q;
        vw_data = {1'b1, best_par_q, best_key_q};
      end
      S_RELAX: begin
        vw_en   = relax_upd;
        vw_addr = pi_q;
        vw_data = {1'b0, cur_q, 1'b0, edge_weight};
      end
      default: begin
        vw_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vw_en) begin
      vtx_mem[vw_addr] <= vw_data;
    end
    vr_q <= vtx_mem[cnt_q];
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    iss_done_d   = iss_done_q;
    pv_d         = 1'b0;
    pi_d         = pi_q;
    top_d        = top_q;
    start_d      = start_q;
    start_ok_d   = start_ok_q;
    cur_d        = cur_q;
    best_key_d   = best_key_q;
    best_par_d   = best_par_q;
    have_d       = have_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_vertex_d = out_vertex_q;
    out_parent_d = out_parent_q;
    out_key_d    = out_key_q;
    out_found_d  = out_found_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (command_i == pmst_pkg::CMD_RUN)) begin
          top_d      = top_cl;
          start_d    = VW'(start_vertex_i);
          start_ok_d = int'(start_vertex_i) <= int'(top_cl);
          cnt_d      = '0;
          state_d    = S_INIT;
        end
      end
      S_INIT: begin
        if (cnt_q == top_q) begin
          cnt_d      = '0;
          iss_done_d = 1'b0;
          have_d     = 1'b0;
          state_d    = S_SCAN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SCAN: begin
        if (!iss_done_q) begin
          pv_d = 1'b1;
          pi_d = cnt_q;
          if (cnt_q == top_q) begin
            iss_done_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (take) begin
          best_key_d = rd_key;
          best_par_d = rd_par;
          cur_d      = pi_q;
          have_d     = 1'b1;
        end
        if (iss_done_q && !pv_q) begin
          // an infinite best key means nothing left is reachable
          state_d = (have_q && !best_key_q[WEIGHT_BITS]) ? S_EMIT : S_END;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = FW'(cur_q);
          out_parent_d = FW'(best_par_q);
          out_key_d    = KFW'(best_key_q);
          out_found_d  = 1'b1;
          out_last_d   = 1'b0;
          cnt_d        = '0;
          iss_done_d   = 1'b0;
          state_d      = S_RELAX;
        end
      end
      S_RELAX: begin
        if (!iss_done_q) begin
          pv_d = 1'b1;
          pi_d = cnt_q;
          if (cnt_q == top_q) begin
            iss_done_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
        if (iss_done_q && !pv_q) begin
          cnt_d      = '0;
          iss_done_d = 1'b0;
          have_d     = 1'b0;
          state_d    = S_SCAN;
        end
      end
      S_END: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_vertex_d = '0;
          out_parent_d = '0;
          out_key_d    = '0;
          out_found_d  = 1'b0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      iss_done_q   <= 1'b0;
      pv_q         <= 1'b0;
      pi_q         <= '0;
      top_q        <= '0;
      start_q      <= '0;
      start_ok_q   <= 1'b0;
      cur_q        <= '0;
      best_key_q   <= '0;
      best_par_q   <= '0;
      have_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_vertex_q <= '0;
      out_parent_q <= '0;
      out_key_q    <= '0;
      out_found_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      iss_done_q   <= iss_done_d;
      pv_q         <= pv_d;
      pi_q         <= pi_d;
      top_q        <= top_d;
      start_q      <= start_d;
      start_ok_q   <= start_ok_d;
      cur_q        <= cur_d;
      best_key_q   <= best_key_d;
      best_par_q   <= best_par_d;
      have_q       <= have_d;
      out_valid_q  <= out_valid_d;
      out_vertex_q <= out_vertex_d;
      out_parent_q <= out_parent_d;
      out_key_q    <= out_key_d;
      out_found_q  <= out_found_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = out_vertex_q;
  assign parent_o    = out_parent_q;
  assign key_o       = out_key_q;
  assign found_o     = out_found_q;
  assign last_o      = out_last_q;

`ifndef NO_ASSERTIONS
  a_emit_has_finite_key : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (have_q && !best_key_q[WEIGHT_BITS]))
    else $error("emitting a vertex without a finite key");

  a_marker_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (!out_found_q && (out_key_q == '0)))
    else $error("end marker carries vertex data");

  a_run_starts_init : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (command_i == pmst_pkg::CMD_RUN)) |=> (state_q == S_INIT))
    else $error("run item did not start key setup");
`endif

endmodule

@@ src/pmst_cmp.sv @@
module pmst_cmp #(
  parameter int unsigned WIDTH = pmst_pkg::WEIGHT_BITS_DEF + 1
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             gt_o
);

  // Single magnitude compare, shared by the key scan and the edge relaxation
  assign gt_o = (a_i > b_i);

endmodule

@@ src/pmst_edge_store.sv @@
module pmst_edge_store #(
  parameter int unsigned VERTICES    = pmst_pkg::VERTICES_DEF,
  parameter int unsigned WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pmst_pkg::edge_ctrl_t       ctrl_i,
  input  logic [$clog2(VERTICES)-1:0] wr_row_i,
  input  logic [$clog2(VERTICES)-1:0] wr_col_i,
  input  logic [WEIGHT_BITS-1:0]     wr_weight_i,
  input  logic [$clog2(VERTICES)-1:0] rd_row_i,
  input  logic [$clog2(VERTICES)-1:0] rd_col_i,
  output logic                       busy_o,
  output logic                       rd_present_o,
  output logic [WEIGHT_BITS-1:0]     rd_weight_o
);

  localparam int unsigned NN = VERTICES * VERTICES;
  localparam int unsigned AW = $clog2(NN);
  localparam int unsigned EW = WEIGHT_BITS + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NN - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(VERTICES);

  logic [EW-1:0] mem [NN];
  logic [EW-1:0] rd_q;
  logic          busy_q, busy_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_addr = AW'(wr_row_i) * ROW_STRIDE + AW'(wr_col_i);
  assign rd_addr = AW'(rd_row_i) * ROW_STRIDE + AW'(rd_col_i);

  // Clear sweep: one entry a cycle, also right after reset
  always_comb begin
    busy_d  = busy_q;
    sweep_d = sweep_q;
    if (ctrl_i.clear) begin
      busy_d  = 1'b1;
      sweep_d = '0;
    end else if (busy_q) begin
      if (sweep_q == LAST_ADDR) begin
        busy_d = 1'b0;
      end else begin
        sweep_d = sweep_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b1;
      sweep_q <= '0;
    end else begin
      busy_q  <= busy_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[sweep_q] <= '0;
    end else if (ctrl_i.write) begin
      mem[wr_addr] <= {ctrl_i.present, wr_weight_i};
    end
    if (ctrl_i.read) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign busy_o       = busy_q;
  assign rd_present_o = rd_q[WEIGHT_BITS];
  assign rd_weight_o  = rd_q[WEIGHT_BITS-1:0];

`ifndef NO_ASSERTIONS
  a_clear_starts_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> busy_q)
    else $error("clear did not start the sweep");

  a_no_write_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !ctrl_i.write)
    else $error("edge write during clear sweep");
`endif

endmodule
